// ===== sv/bdsc_pkg.sv =====
// Package for the broadcast duplicate suppression cache.
// Holds sizes, controller state codes and the command/status structs.
package bdsc_pkg;

    localparam int CACHE_DEPTH = 4;
    localparam int MSG_BYTES   = 16;
    localparam int SLOT_W      = $clog2(CACHE_DEPTH);
    localparam int BYTE_W      = $clog2(MSG_BYTES);
    localparam int CNT_W       = $clog2(MSG_BYTES + 1);
    localparam int MEM_DEPTH   = CACHE_DEPTH * MSG_BYTES;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int MASK_W      = 4;

    // Controller state codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CMP   = 3'd1;
    localparam logic [2:0] ST_CMPW  = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_SEND  = 3'd5;
    localparam logic [2:0] ST_SENDW = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    typedef struct packed {
        logic              take_byte;  // store incoming byte
        logic              clr_msg;    // reset incoming count/overflow
        logic              rd_en;      // issue memory read
        logic [SLOT_W-1:0] slot;       // entry addressed
        logic [BYTE_W-1:0] pos;        // byte position addressed
        logic              cmp_clr;    // start compare of an entry
        logic              copy;       // copy incoming byte into slot
        logic              commit;     // write size/channel/pending
        logic              clr_pend;   // clear pending of slot
        logic              load_verd;  // load verdict into output reg
        logic              load_byte;  // load sent byte into output reg
        logic              verd_dup;
        logic              verd_tl;
        logic              out_last;
    } bdsc_cmd_t;

    typedef struct packed {
        logic              overflow;
        logic [CNT_W-1:0]  count;
        logic              size_eq;    // entry size equals incoming count
        logic              bytes_eq;   // all compared bytes matched so far
        logic [CACHE_DEPTH-1:0] pending;
        logic [CNT_W-1:0]  slot_size;
        logic [SLOT_W-1:0] next_slot;
        logic              out_busy;
    } bdsc_stat_t;

endpackage

// ===== sv/bdsc_datapath.sv =====
// Datapath: incoming buffer, entry store, entry tables and output register.
// Depends on bdsc_pkg.
module bdsc_datapath import bdsc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bdsc_cmd_t             cmd,
    output bdsc_stat_t            stat,
    input  logic [7:0]            s_data_byte,
    input  logic [7:0]            s_msg_channel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_kind,
    output logic                  m_duplicate,
    output logic                  m_too_long,
    output logic [1:0]            m_entry_index,
    output logic [7:0]            m_out_byte,
    output logic [7:0]            m_out_channel,
    output logic [4:0]            m_out_size,
    output logic                  m_last
);

    logic [7:0]        inc_mem [MSG_BYTES];
    logic [7:0]        ent_mem [MEM_DEPTH];
    logic [CNT_W-1:0]  size_reg [CACHE_DEPTH];
    logic [7:0]        chan_reg [CACHE_DEPTH];
    logic [7:0]        chan_in_reg;
    logic [CACHE_DEPTH-1:0] pend_reg;
    logic [SLOT_W-1:0] next_slot_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;
    logic [7:0]        inc_rd_reg, ent_rd_reg;
    logic              eq_reg;
    logic [ADDR_W-1:0] addr;
    logic              out_valid_reg;

    assign addr = ADDR_W'({cmd.slot, cmd.pos});

    // Incoming message buffer
    always_ff @(posedge aclk) begin
        if (cmd.take_byte && count_reg < CNT_W'(MSG_BYTES)) begin
            inc_mem[count_reg[BYTE_W-1:0]] <= s_data_byte;
        end
        if (cmd.take_byte) begin
            chan_in_reg <= s_msg_channel;
        end
        if (cmd.rd_en) begin
            inc_rd_reg <= inc_mem[cmd.pos];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.clr_msg) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.take_byte) begin
            if (count_reg < CNT_W'(MSG_BYTES)) begin
                count_reg <= count_reg + 1'b1;
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Entry byte store: one write or one read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.copy) begin
            ent_mem[addr] <= inc_rd_reg;
        end else if (cmd.rd_en) begin
            ent_rd_reg <= ent_mem[addr];
        end
    end

    // Running byte compare
    always_ff @(posedge aclk) begin
        if (cmd.cmp_clr) begin
            eq_reg <= 1'b1;
        end else if (inc_rd_reg != ent_rd_reg) begin
            eq_reg <= 1'b0;
        end
    end

    // Entry tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= '0;
            next_slot_reg <= '0;
            for (int i = 0; i < CACHE_DEPTH; i++) begin
                size_reg[i] <= '0;
                chan_reg[i] <= '0;
            end
        end else begin
            if (cmd.commit) begin
                size_reg[cmd.slot] <= count_reg;
                chan_reg[cmd.slot] <= chan_in_reg;
                pend_reg[cmd.slot] <= 1'b1;
                next_slot_reg <= (next_slot_reg == SLOT_W'(CACHE_DEPTH - 1)) ?
                                 '0 : next_slot_reg + 1'b1;
            end
            if (cmd.clr_pend) begin
                pend_reg[cmd.slot] <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_verd || cmd.load_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_verd) begin
            m_kind        <= 1'b0;
            m_duplicate   <= cmd.verd_dup;
            m_too_long    <= cmd.verd_tl;
            m_entry_index <= 2'(cmd.slot);
            m_out_byte    <= '0;
            m_out_channel <= '0;
            m_out_size    <= '0;
            m_last        <= cmd.out_last;
        end else if (cmd.load_byte) begin
            m_kind        <= 1'b1;
            m_duplicate   <= 1'b0;
            m_too_long    <= 1'b0;
            m_entry_index <= 2'(cmd.slot);
            m_out_byte    <= ent_rd_reg;
            m_out_channel <= chan_reg[cmd.slot];
            m_out_size    <= 5'(size_reg[cmd.slot]);
            m_last        <= cmd.out_last;
        end
    end

    assign m_valid = out_valid_reg;

    assign stat.overflow  = ovf_reg;
    assign stat.count     = count_reg;
    assign stat.size_eq   = size_reg[cmd.slot] == count_reg;
    assign stat.bytes_eq  = eq_reg;
    assign stat.pending   = pend_reg;
    assign stat.slot_size = size_reg[cmd.slot];
    assign stat.next_slot = next_slot_reg;
    assign stat.out_busy  = out_valid_reg && !m_ready;

endmodule

// ===== sv/bdsc_ctrl.sv =====
// Controller: sequences the compare walk, the slot write and the send pass.
// Depends on bdsc_pkg.
module bdsc_ctrl import bdsc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_func,
    input  logic             s_last_byte,
    input  logic [3:0]       s_send_ok_mask,
    input  bdsc_stat_t       stat,
    output bdsc_cmd_t        cmd
);

    logic [2:0]        state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic              last_pend_reg, last_pend_next;
    logic              acc;
    logic              send_ok;
    logic              more;
    logic [BYTE_W-1:0] pos_b;

    assign acc   = s_valid && s_ready;
    assign pos_b = pos_reg[BYTE_W-1:0];

    // Does any later pending, enabled slot remain after slot_reg
    always_comb begin
        more = 1'b0;
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (i > int'(slot_reg) && i < MASK_W && stat.pending[i] && mask_reg[i % MASK_W])
            begin
                more = 1'b1;
            end
        end
    end

    assign send_ok = (int'(slot_reg) < MASK_W) && stat.pending[slot_reg]
                     && mask_reg[slot_reg % MASK_W];

    always_comb begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        pos_next       = pos_reg;
        mask_next      = mask_reg;
        last_pend_next = last_pend_reg;
        cmd            = '0;
        cmd.slot       = slot_reg;
        cmd.pos        = pos_b;
        s_ready        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = !stat.out_busy;
                if (acc) begin
                    if (s_func) begin
                        mask_next  = s_send_ok_mask;
                        slot_next  = '0;
                        state_next = ST_SCAN;
                    end else begin
                        cmd.take_byte = 1'b1;
                        if (s_last_byte) begin
                            slot_next  = '0;
                            pos_next   = '0;
                            state_next = ST_CMP;
                        end
                    end
                end
            end
            // Compare entry slot_reg one byte at a time: read in ST_CMP, wait in ST_CMPW, check in ST_OUT
            ST_CMP: begin
                if (stat.overflow) begin
                    cmd.slot      = '0;
                    cmd.load_verd = 1'b1;
                    cmd.verd_tl   = 1'b1;
                    cmd.out_last  = 1'b1;
                    cmd.clr_msg   = 1'b1;
                    state_next    = ST_IDLE;
                end else if (pos_reg == '0) begin
                    cmd.cmp_clr = 1'b1;
                    if (stat.size_eq) begin
                        cmd.rd_en  = 1'b1;
                        state_next = ST_CMPW;
                    end else if (slot_reg == SLOT_W'(CACHE_DEPTH - 1)) begin
                        slot_next  = stat.next_slot;
                        state_next = ST_WRITE;
                    end else begin
                        slot_next = slot_reg + 1'b1;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_CMPW;
                end
            end
            ST_CMPW: begin
                // read data valid now; compare registers next edge
                pos_next   = pos_reg + 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // compare result of position pos_reg-1 folded into bytes_eq
                if (!stat.bytes_eq) begin
                    pos_next = '0;
                    if (slot_reg == SLOT_W'(CACHE_DEPTH - 1)) begin
                        slot_next  = stat.next_slot;
                        state_next = ST_WRITE;
                    end else begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_CMP;
                    end
                end else if (pos_reg == stat.count) begin
                    cmd.load_verd = 1'b1;
                    cmd.verd_dup  = 1'b1;
                    cmd.out_last  = 1'b1;
                    cmd.clr_msg   = 1'b1;
                    pos_next      = '0;
                    state_next    = ST_IDLE;
                end else begin
                    state_next = ST_CMP;
                end
            end
            // Copy incoming bytes into slot: read then write
            ST_WRITE: begin
                if (pos_reg[CNT_W-1] == 1'b0 && !last_pend_reg) begin
                    cmd.rd_en      = 1'b1;
                    last_pend_next = 1'b1;
                end else if (last_pend_reg) begin
                    cmd.copy       = 1'b1;
                    last_pend_next = 1'b0;
                    pos_next       = pos_reg + 1'b1;
                    if (pos_reg + 1'b1 == stat.count) begin
                        pos_next       = CNT_W'(1) << (CNT_W - 1);
                    end
                end else begin
                    cmd.commit    = 1'b1;
                    cmd.load_verd = 1'b1;
                    cmd.out_last  = 1'b1;
                    cmd.clr_msg   = 1'b1;
                    pos_next      = '0;
                    state_next    = ST_IDLE;
                end
            end
            // Find next sendable slot
            ST_SCAN: begin
                if (send_ok) begin
                    pos_next   = '0;
                    state_next = ST_SEND;
                end else if (slot_reg == SLOT_W'(CACHE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_SEND: begin
                if (!stat.out_busy) begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_SENDW;
                end
            end
            ST_SENDW: begin
                cmd.load_byte = 1'b1;
                pos_next      = pos_reg + 1'b1;
                if (pos_reg + 1'b1 == stat.slot_size) begin
                    cmd.clr_pend = 1'b1;
                    cmd.out_last = !more;
                    pos_next     = '0;
                    if (more) begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_SEND;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            pos_reg       <= '0;
            mask_reg      <= '0;
            last_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            pos_reg       <= pos_next;
            mask_reg      <= mask_next;
            last_pend_reg <= last_pend_next;
        end
    end

endmodule

// ===== sv/broadcast_duplicate_suppression_cache.sv =====
// Top level of the broadcast duplicate suppression cache.
// Depends on bdsc_pkg, bdsc_ctrl and bdsc_datapath.
//
//  channel | handshake          | payload
//  s_      | s_valid / s_ready  | func, data_byte, last_byte, msg_channel, send_ok_mask
//  m_      | m_valid / m_ready  | kind, duplicate, too_long, entry_index, out_byte,
//          |                    | out_channel, out_size, last
//
// A final byte walks the 4 entries through the single-port entry store, one compared
// byte at a time, then copies the message into a new entry if none matched. A send
// pass outputs every byte of each pending slot that send_ok_mask enables.
// Reset is synchronous, active low, and clears all control and entry tables.
// A stalled result register holds the send pass; s_ready is low while a walk or send runs.
module broadcast_duplicate_suppression_cache import bdsc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    input  logic [7:0] s_msg_channel,
    input  logic [3:0] s_send_ok_mask,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic       m_duplicate,
    output logic       m_too_long,
    output logic [1:0] m_entry_index,
    output logic [7:0] m_out_byte,
    output logic [7:0] m_out_channel,
    output logic [4:0] m_out_size,
    output logic       m_last
);

    bdsc_cmd_t  cmd;
    bdsc_stat_t stat;

    bdsc_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_func, .s_last_byte,
        .s_send_ok_mask, .stat, .cmd
    );

    bdsc_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat, .s_data_byte, .s_msg_channel,
        .m_valid, .m_ready, .m_kind, .m_duplicate, .m_too_long, .m_entry_index,
        .m_out_byte, .m_out_channel, .m_out_size, .m_last
    );

    // Never load a new result over one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_verd || cmd.load_byte) |-> !stat.out_busy)
        else $error("result overwritten");

    // A verdict is never both duplicate and too long
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_kind) |-> !(m_duplicate && m_too_long))
        else $error("bad verdict");

    // Commit and pending clear never collide
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.commit && cmd.clr_pend))
        else $error("commit during send");

endmodule
